### design/aabbat_pkg.sv
package aabbat_pkg;

  // Field widths and fixed-point formats
  localparam int COORD_W   = 32;             // Q16.16 coordinates
  localparam int COEF_W    = 16;             // Q3.12 coefficients
  localparam int FRAC_COEF = 12;             // fraction bits of a coefficient
  localparam int ROW_W     = 3 * COEF_W;     // one packed matrix row
  localparam int PROD_W    = COEF_W + COORD_W;
  localparam int SUM_W     = PROD_W + 2;     // three products plus translation
  localparam int RND_W     = SUM_W - FRAC_COEF;

  // Configuration port
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;
  localparam int REG_LSB    = 3;             // registers on 8-byte boundaries

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_ROW_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

  // Reset values: identity matrix, no translation
  localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h1000_0000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [ROW_W-1:0]          row_t;

  typedef coord_t [2:0]      vec3_t;
  typedef row_t   [2:0]      rows_t;
  typedef prod_t  [2:0][2:0] prod_grid_t;   // [output axis][input axis]
  typedef sum_t   [2:0]      sum_vec_t;

  // Transform as held in the register file
  typedef struct packed {
    rows_t rows;
    vec3_t shift;
  } xform_t;

  // Coefficient of input axis col within a packed row
  function automatic coef_t coef_of(row_t row, int col);
    coef_t c;
    c = row[col*COEF_W +: COEF_W];
    return c;
  endfunction

  // Round Q.28 to Q16.16 (half toward plus infinity), then saturate to 32 bits
  function automatic coord_t round_sat(sum_t v);
    sum_t                    b;
    logic [RND_W-1:0]        r;
    logic [RND_W-COORD_W:0]  top;
    coord_t                  res;
    b   = v + sum_t'(1 << (FRAC_COEF - 1));
    r   = b[SUM_W-1:FRAC_COEF];
    top = r[RND_W-1:COORD_W-1];
    if (top == '0 || top == '1) begin
      res = r[COORD_W-1:0];
    end else if (r[RND_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### design/aabbat_cfg_regs.sv
module aabbat_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aabbat_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [aabbat_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [aabbat_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready,
  output aabbat_pkg::xform_t                  xform
);
  import aabbat_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;
  row_t                 row_x, row_y, row_z;
  coord_t               shift_x, shift_y, shift_z;

  assign pready = 1'b1;
  assign idx    = paddr[APB_ADDR_W-1:REG_LSB];
  assign wr_en  = psel && penable && pwrite;

  // Register writes; indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      row_x   <= ROW_X_RESET;
      row_y   <= ROW_Y_RESET;
      row_z   <= ROW_Z_RESET;
      shift_x <= '0;
      shift_y <= '0;
      shift_z <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROW_X:   row_x   <= pwdata[ROW_W-1:0];
        REG_ROW_Y:   row_y   <= pwdata[ROW_W-1:0];
        REG_ROW_Z:   row_z   <= pwdata[ROW_W-1:0];
        REG_SHIFT_X: shift_x <= pwdata[COORD_W-1:0];
        REG_SHIFT_Y: shift_y <= pwdata[COORD_W-1:0];
        REG_SHIFT_Z: shift_z <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_ROW_X:   prdata = {{(APB_DATA_W-ROW_W){1'b0}}, row_x};
      REG_ROW_Y:   prdata = {{(APB_DATA_W-ROW_W){1'b0}}, row_y};
      REG_ROW_Z:   prdata = {{(APB_DATA_W-ROW_W){1'b0}}, row_z};
      REG_SHIFT_X: prdata = {{(APB_DATA_W-COORD_W){1'b0}}, shift_x};
      REG_SHIFT_Y: prdata = {{(APB_DATA_W-COORD_W){1'b0}}, shift_y};
      REG_SHIFT_Z: prdata = {{(APB_DATA_W-COORD_W){1'b0}}, shift_z};
      default:     prdata = '0;
    endcase
  end

  assign xform.rows  = {row_z, row_y, row_x};
  assign xform.shift = {shift_z, shift_y, shift_x};

  // A write to an unused index leaves the register file unchanged
  a_unused_write_ignored: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (idx > REG_SHIFT_Z)) |=> $stable(xform))
    else $error("write to unused register index changed the transform");

endmodule

### design/aabbat_mul_stage.sv
module aabbat_mul_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     ready_in,
  input  aabbat_pkg::vec3_t        lo,
  input  aabbat_pkg::vec3_t        hi,
  input  aabbat_pkg::rows_t        rows,
  output logic                     valid,
  input  logic                     ready_out,
  output aabbat_pkg::prod_grid_t   prod_lo,
  output aabbat_pkg::prod_grid_t   prod_hi
);
  import aabbat_pkg::*;

  prod_grid_t plo_next, phi_next;

  assign ready_in = !valid || ready_out;

  // Every coefficient against both corner coordinates of its input axis
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        plo_next[r][c] = coef_of(rows[r], c) * lo[c];
        phi_next[r][c] = coef_of(rows[r], c) * hi[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && in_valid) begin
      prod_lo <= plo_next;
      prod_hi <= phi_next;
    end
  end

endmodule

### design/aabbat_minmax_stage.sv
module aabbat_minmax_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     ready_in,
  input  aabbat_pkg::prod_grid_t   prod_lo,
  input  aabbat_pkg::prod_grid_t   prod_hi,
  output logic                     valid,
  input  logic                     ready_out,
  output aabbat_pkg::prod_grid_t   term_min,
  output aabbat_pkg::prod_grid_t   term_max
);
  import aabbat_pkg::*;

  prod_grid_t tmin_next, tmax_next;

  assign ready_in = !valid || ready_out;

  // Smaller and larger product of each coefficient pair
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ($signed(prod_lo[r][c]) < $signed(prod_hi[r][c])) begin
          tmin_next[r][c] = prod_lo[r][c];
          tmax_next[r][c] = prod_hi[r][c];
        end else begin
          tmin_next[r][c] = prod_hi[r][c];
          tmax_next[r][c] = prod_lo[r][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && in_valid) begin
      term_min <= tmin_next;
      term_max <= tmax_next;
    end
  end

endmodule

### design/aabbat_sum_stage.sv
module aabbat_sum_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     ready_in,
  input  aabbat_pkg::prod_grid_t   term_min,
  input  aabbat_pkg::prod_grid_t   term_max,
  input  aabbat_pkg::vec3_t        shift,
  output logic                     valid,
  input  logic                     ready_out,
  output aabbat_pkg::sum_vec_t     sum_min,
  output aabbat_pkg::sum_vec_t     sum_max
);
  import aabbat_pkg::*;

  sum_vec_t smin_next, smax_next;
  sum_vec_t base;

  assign ready_in = !valid || ready_out;

  // Translation aligned to Q.28, plus the three selected products per axis
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      base[r] = {{(SUM_W-COORD_W-FRAC_COEF){shift[r][COORD_W-1]}}, shift[r],
                 {FRAC_COEF{1'b0}}};
      smin_next[r] = base[r]
        + {{(SUM_W-PROD_W){term_min[r][0][PROD_W-1]}}, term_min[r][0]}
        + {{(SUM_W-PROD_W){term_min[r][1][PROD_W-1]}}, term_min[r][1]}
        + {{(SUM_W-PROD_W){term_min[r][2][PROD_W-1]}}, term_min[r][2]};
      smax_next[r] = base[r]
        + {{(SUM_W-PROD_W){term_max[r][0][PROD_W-1]}}, term_max[r][0]}
        + {{(SUM_W-PROD_W){term_max[r][1][PROD_W-1]}}, term_max[r][1]}
        + {{(SUM_W-PROD_W){term_max[r][2][PROD_W-1]}}, term_max[r][2]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && in_valid) begin
      sum_min <= smin_next;
      sum_max <= smax_next;
    end
  end

endmodule

### design/aabbat_round_stage.sv
module aabbat_round_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     ready_in,
  input  aabbat_pkg::sum_vec_t     sum_min,
  input  aabbat_pkg::sum_vec_t     sum_max,
  output logic                     valid,
  input  logic                     ready_out,
  output aabbat_pkg::vec3_t        box_lo,
  output aabbat_pkg::vec3_t        box_hi
);
  import aabbat_pkg::*;

  vec3_t lo_next, hi_next;

  assign ready_in = !valid || ready_out;

  // Round to Q16.16 and clamp; this register is the output register
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lo_next[r] = round_sat(sum_min[r]);
      hi_next[r] = round_sat(sum_max[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && in_valid) begin
      box_lo <= lo_next;
      box_hi <= hi_next;
    end
  end

endmodule

### design/aabb_affine_transform_core.sv
// Affine transform of an axis-aligned 3D box.
// Input channel (in_valid / in_stall): one box per transaction, minimum and
// maximum corners in signed Q16.16. Output channel (out_valid / out_stall):
// the box enclosing the eight mapped corners, rounded and saturated Q16.16.
// The 3x3 Q3.12 matrix and the Q16.16 translation sit in an APB register file
// (64-bit data, registers at 8-byte steps); change them only while idle.
// Pipeline: four register stages (multiply, min/max select, sum and
// round/saturate). Throughput: one box per cycle while out_stall is low;
// each stage holds one transaction and has its own valid bit, so bubbles
// close up when the output is stalled.
// When out_stall is high the output register holds its transaction and the
// stages behind it keep filling; in_stall rises once all four stages are full.
// Reset clears every valid bit and loads the identity transform with zero
// translation.
module aabb_affine_transform_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aabbat_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [aabbat_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [aabbat_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  aabbat_pkg::coord_t                  lo_x,
  input  aabbat_pkg::coord_t                  lo_y,
  input  aabbat_pkg::coord_t                  lo_z,
  input  aabbat_pkg::coord_t                  hi_x,
  input  aabbat_pkg::coord_t                  hi_y,
  input  aabbat_pkg::coord_t                  hi_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output aabbat_pkg::coord_t                  out_lo_x,
  output aabbat_pkg::coord_t                  out_lo_y,
  output aabbat_pkg::coord_t                  out_lo_z,
  output aabbat_pkg::coord_t                  out_hi_x,
  output aabbat_pkg::coord_t                  out_hi_y,
  output aabbat_pkg::coord_t                  out_hi_z
);
  import aabbat_pkg::*;

  xform_t     xform;
  vec3_t      in_lo, in_hi, box_lo, box_hi;
  prod_grid_t prod_lo, prod_hi, term_min, term_max;
  sum_vec_t   sum_min, sum_max;
  logic       s1_valid, s2_valid, s3_valid;
  logic       s1_ready, s2_ready, s3_ready, s4_ready;

  assign in_lo = {lo_z, lo_y, lo_x};
  assign in_hi = {hi_z, hi_y, hi_x};

  aabbat_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .xform   (xform)
  );

  // Stage 1: eighteen coefficient products
  aabbat_mul_stage u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .ready_in  (s1_ready),
    .lo        (in_lo),
    .hi        (in_hi),
    .rows      (xform.rows),
    .valid     (s1_valid),
    .ready_out (s2_ready),
    .prod_lo   (prod_lo),
    .prod_hi   (prod_hi)
  );

  // Stage 2: order each lo/hi product pair
  aabbat_minmax_stage u_minmax (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .ready_in  (s2_ready),
    .prod_lo   (prod_lo),
    .prod_hi   (prod_hi),
    .valid     (s2_valid),
    .ready_out (s3_ready),
    .term_min  (term_min),
    .term_max  (term_max)
  );

  // Stage 3: per-axis sums with translation
  aabbat_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .ready_in  (s3_ready),
    .term_min  (term_min),
    .term_max  (term_max),
    .shift     (xform.shift),
    .valid     (s3_valid),
    .ready_out (s4_ready),
    .sum_min   (sum_min),
    .sum_max   (sum_max)
  );

  // Stage 4: round, saturate, output register
  aabbat_round_stage u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .ready_in  (s4_ready),
    .sum_min   (sum_min),
    .sum_max   (sum_max),
    .valid     (out_valid),
    .ready_out (!out_stall),
    .box_lo    (box_lo),
    .box_hi    (box_hi)
  );

  assign in_stall = !s1_ready;

  assign out_lo_x = box_lo[0];
  assign out_lo_y = box_lo[1];
  assign out_lo_z = box_lo[2];
  assign out_hi_x = box_hi[0];
  assign out_hi_y = box_hi[1];
  assign out_hi_z = box_hi[2];

  // An empty first stage never pushes back on the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with first stage empty");

  // An accepted transaction always lands in the first stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted transaction lost at first stage");

  // Enclosing box is never inverted
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_lo_x) <= $signed(out_hi_x)) &&
                  ($signed(out_lo_y) <= $signed(out_hi_y)) &&
                  ($signed(out_lo_z) <= $signed(out_hi_z)))
    else $error("output minimum corner above maximum corner");

endmodule

### dv/aabb_affine_transform_checker.sv
module aabb_affine_transform_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [aabbat_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [aabbat_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  aabbat_pkg::coord_t                lo_x,
  input  aabbat_pkg::coord_t                lo_y,
  input  aabbat_pkg::coord_t                lo_z,
  input  aabbat_pkg::coord_t                hi_x,
  input  aabbat_pkg::coord_t                hi_y,
  input  aabbat_pkg::coord_t                hi_z,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  aabbat_pkg::coord_t                out_lo_x,
  input  aabbat_pkg::coord_t                out_lo_y,
  input  aabbat_pkg::coord_t                out_lo_z,
  input  aabbat_pkg::coord_t                out_hi_x,
  input  aabbat_pkg::coord_t                out_hi_y,
  input  aabbat_pkg::coord_t                out_hi_z,
  input  logic                              drain_check,
  output int                                fail_count
);
  import aabbat_pkg::*;

  typedef struct packed {
    vec3_t lo;
    vec3_t hi;
  } box_t;

  localparam longint COORD_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint COORD_MIN   = -64'sh0000_0000_8000_0000;
  localparam longint HALF_LSB    = longint'(1) << (FRAC_COEF - 1);

  // Local copy of the transform registers
  row_t   matrix [3];
  coord_t offset [3];

  // Mapped boxes waiting for their output transaction
  box_t   mapped_boxes [$];

  box_t                  given, seen, want;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  drained;
  int                    axis;
  string                 axis_tag [3] = '{"x", "y", "z"};

  // Q.28 to Q16.16, half rounds up, then clamp to 32 bits
  function automatic coord_t round_clamp(longint acc);
    longint q;
    q = (acc + HALF_LSB) >>> FRAC_COEF;
    if (q > COORD_MAX) begin
      q = COORD_MAX;
    end else if (q < COORD_MIN) begin
      q = COORD_MIN;
    end
    return coord_t'(q);
  endfunction

  // Enclosing box of the eight mapped corners: per output axis, sum the
  // smaller and the larger product of each coefficient with lo and hi
  function automatic box_t map_box(box_t b);
    box_t   m;
    coef_t  k;
    longint a, p, q, acc_lo, acc_hi;
    int     r, c;
    for (r = 0; r < 3; r++) begin
      acc_lo = longint'($signed(offset[r])) <<< FRAC_COEF;
      acc_hi = acc_lo;
      for (c = 0; c < 3; c++) begin
        k = matrix[r][c*COEF_W +: COEF_W];
        a = k;
        p = a * longint'($signed(b.lo[c]));
        q = a * longint'($signed(b.hi[c]));
        if (p < q) begin
          acc_lo += p;
          acc_hi += q;
        end else begin
          acc_lo += q;
          acc_hi += p;
        end
      end
      m.lo[r] = round_clamp(acc_lo);
      m.hi[r] = round_clamp(acc_hi);
    end
    return m;
  endfunction

  task automatic note_mismatch(input string field, input coord_t exp_v,
                               input coord_t got_v);
    $display("%0t: %s mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
             $time, field, exp_v, exp_v, got_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      matrix[0] = ROW_X_RESET;
      matrix[1] = ROW_Y_RESET;
      matrix[2] = ROW_Z_RESET;
      offset[0] = '0;
      offset[1] = '0;
      offset[2] = '0;
      mapped_boxes.delete();
      fail_count = 0;
      drained = 1'b0;
    end else begin
      // Register writes track the block's transform
      if (psel && penable && pwrite && pready) begin
        reg_idx = paddr[REG_LSB +: REG_IDX_W];
        case (reg_idx)
          REG_ROW_X, REG_ROW_Y, REG_ROW_Z: begin
            matrix[reg_idx] = pwdata[ROW_W-1:0];
          end
          REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z: begin
            offset[reg_idx - REG_SHIFT_X] = pwdata[COORD_W-1:0];
          end
          default: ;  // unmapped index, write dropped
        endcase
      end

      // Input transaction: predict its box
      if (in_valid && !in_stall) begin
        given.lo = {lo_z, lo_y, lo_x};
        given.hi = {hi_z, hi_y, hi_x};
        mapped_boxes.push_back(map_box(given));
      end

      // Output transaction: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        seen.lo = {out_lo_z, out_lo_y, out_lo_x};
        seen.hi = {out_hi_z, out_hi_y, out_hi_x};
        if (mapped_boxes.size() == 0) begin
          $display({"%0t: output with no box pending: expected none, ",
                    "actual lo %0d %0d %0d hi %0d %0d %0d"},
                   $time, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z);
          fail_count++;
        end else begin
          want = mapped_boxes.pop_front();
          for (axis = 0; axis < 3; axis++) begin
            if (seen.lo[axis] !== want.lo[axis]) begin
              note_mismatch({"out_lo_", axis_tag[axis]}, want.lo[axis], seen.lo[axis]);
            end
            if (seen.hi[axis] !== want.hi[axis]) begin
              note_mismatch({"out_hi_", axis_tag[axis]}, want.hi[axis], seen.hi[axis]);
            end
          end
        end
      end

      // End of run: anything still pending never came out
      if (drain_check && !drained) begin
        drained = 1'b1;
        if (mapped_boxes.size() != 0) begin
          $display("%0t: %0d boxes never came out: expected 0 pending, actual %0d",
                   $time, mapped_boxes.size(), mapped_boxes.size());
          fail_count += mapped_boxes.size();
        end
      end
    end
  end

endmodule

### dv/aabb_affine_transform_core_tb.sv
module aabb_affine_transform_core_tb;
  import aabbat_pkg::*;

  typedef enum {ROW_RANDOM, ROW_EXTREME, ROW_HALVES} row_style_t;

  localparam int     PHASES          = 9;
  localparam int     BOXES_PER_PHASE = 200;
  localparam int     HOLD_CYCLES     = 48;
  localparam int     SETTLE_CYCLES   = 8;
  localparam int     RESET_CYCLES    = 11;
  localparam int     CYCLE_LIMIT     = 400000;
  localparam coord_t CMAX            = 32'sh7FFF_FFFF;
  localparam coord_t CMIN            = 32'sh8000_0000;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = REG_SHIFT_Z + 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = '1;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  coord_t                lo_x        = '0;
  coord_t                lo_y        = '0;
  coord_t                lo_z        = '0;
  coord_t                hi_x        = '0;
  coord_t                hi_y        = '0;
  coord_t                hi_z        = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  coord_t                out_lo_x, out_lo_y, out_lo_z;
  coord_t                out_hi_x, out_hi_y, out_hi_z;
  logic                  drain_check = 1'b0;
  int                    fail_count;

  int boxes_in      = 0;
  int boxes_out     = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int holds_asked   = 0;
  int holds_done    = 0;

  aabb_affine_transform_core dut (.*);

  aabb_affine_transform_checker box_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Transaction counts and run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && in_valid && !in_stall) begin
      boxes_in <= boxes_in + 1;
    end
    if (!rst && out_valid && !out_stall) begin
      boxes_out <= boxes_out + 1;
    end
  end

  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("aabb_affine_transform_core_tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done < holds_asked) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << REG_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Unused upper data bits carry noise; the unmapped slots get written too
  task automatic load_transform(input row_t rx, input row_t ry, input row_t rz,
                                input coord_t sx, input coord_t sy, input coord_t sz);
    write_reg(REG_ROW_X, {16'($urandom), rx});
    write_reg(REG_ROW_Y, {16'($urandom), ry});
    write_reg(REG_ROW_Z, {16'($urandom), rz});
    write_reg(REG_SHIFT_X, {32'($urandom), sx});
    write_reg(REG_SHIFT_Y, {32'($urandom), sy});
    write_reg(REG_SHIFT_Z, {32'($urandom), sz});
    write_reg(REG_SPARE_LO, {32'($urandom), 32'($urandom)});
    write_reg(REG_SPARE_HI, {32'($urandom), 32'($urandom)});
  endtask

  function automatic row_t pick_row(row_style_t style);
    row_t  row;
    coef_t k;
    int    c;
    row = '0;
    for (c = 0; c < 3; c++) begin
      case (style)
        ROW_EXTREME: begin
          case ($urandom_range(7))
            0: k = 16'h7FFF;
            1: k = 16'h8000;
            2: k = 16'h0000;
            3: k = 16'h1000;
            4: k = 16'hF000;
            5: k = 16'h0001;
            6: k = 16'hFFFF;
            default: k = 16'($urandom);
          endcase
        end
        // half-unit coefficients put odd products exactly on a tie
        ROW_HALVES: begin
          case ($urandom_range(2))
            0: k = 16'h0800;
            1: k = 16'hF800;
            default: k = 16'h0000;
          endcase
        end
        default: k = 16'($urandom);
      endcase
      row[c*COEF_W +: COEF_W] = k;
    end
    return row;
  endfunction

  task automatic setup_phase(input int phase_no);
    case (phase_no)
      0: ;  // reset transform: identity, no translation
      1: load_transform(ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET, CMAX, CMAX, CMAX);
      2: load_transform({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, CMIN, CMIN, CMIN);
      3: load_transform({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, '0, '0, '0);
      4: load_transform(pick_row(ROW_HALVES), pick_row(ROW_HALVES), pick_row(ROW_HALVES),
                        $urandom, $urandom, $urandom);
      5: load_transform('0, '0, '0, $urandom, $urandom, $urandom);
      6: load_transform(pick_row(ROW_EXTREME), pick_row(ROW_EXTREME), pick_row(ROW_EXTREME),
                        $urandom, $urandom, $urandom);
      default: load_transform(pick_row(ROW_RANDOM), pick_row(ROW_RANDOM), pick_row(ROW_RANDOM),
                              $urandom, $urandom, $urandom);
    endcase
  endtask

  function automatic coord_t extreme_coord();
    case ($urandom_range(5))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      3: return 32'hFFFF_FFFF;
      4: return 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mix of full-range, ordinary, inverted and extreme-valued boxes
  task automatic make_box(output vec3_t lo, output vec3_t hi);
    int     style, centre, span, a;
    coord_t t;
    style = $urandom_range(99);
    for (a = 0; a < 3; a++) begin
      if (style < 35) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else if (style < 90) begin
        centre = $urandom_range(0, 1 << 23) - (1 << 22);
        span   = $urandom_range(0, 1 << 20);
        lo[a]  = centre - span;
        hi[a]  = centre + span;
        if (style >= 80) begin
          t     = lo[a];
          lo[a] = hi[a];
          hi[a] = t;
        end
      end else begin
        lo[a] = extreme_coord();
        hi[a] = extreme_coord();
      end
    end
  endtask

  // Offer one box, with random idle cycles ahead of it; valid stays high after
  task automatic send_box(input vec3_t lo, input vec3_t hi);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    lo_x <= lo[0];
    lo_y <= lo[1];
    lo_z <= lo[2];
    hi_x <= hi[0];
    hi_y <= hi[1];
    hi_z <= hi[2];
    do @(posedge clk); while (in_stall);
  endtask

  // Field extremes and inverted boxes
  task automatic send_corner_boxes();
    send_box('0, '0);
    send_box({3{CMAX}}, {3{CMAX}});
    send_box({3{CMIN}}, {3{CMIN}});
    send_box({3{CMIN}}, {3{CMAX}});
    send_box({3{CMAX}}, {3{CMIN}});
    send_box({3{32'hFFFF_FFFF}}, {3{32'h0000_0001}});
    send_box({3{32'h0000_8000}}, {3{32'hFFFF_8000}});
    send_box({CMAX, 32'h0000_0000, CMIN}, {CMIN, 32'h0001_0000, CMAX});
  endtask

  // Wait on a clock edge first so the counters include the last accepted transaction
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (boxes_out != boxes_in) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int    phase_no, n;
    vec3_t lo, hi;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    for (phase_no = 0; phase_no < PHASES; phase_no++) begin
      if (phase_no != 0) begin
        wait_idle();
      end
      setup_phase(phase_no);
      // idle pattern: sender light / receiver heavy, then swapped, then none
      case (phase_no / 3)
        0: begin
          send_idle_pct = 8;
          stall_pct     = 83;
        end
        1: begin
          send_idle_pct = 83;
          stall_pct     = 8;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      if (phase_no == 1 || phase_no == 6) begin
        holds_asked++;
      end
      if (phase_no == 0 || phase_no == 2) begin
        send_corner_boxes();
      end
      for (n = 0; n < BOXES_PER_PHASE; n++) begin
        make_box(lo, hi);
        send_box(lo, hi);
      end
    end
    wait_idle();
    drain_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("aabb_affine_transform_core_tb: PASS");
    end else begin
      $display("aabb_affine_transform_core_tb: FAIL");
    end
    $finish;
  end

endmodule
